[src/gzsb_pkg.sv]
// ----------------------------------------------------------------------------
// gzsb_pkg
// Shared types, constants and functions of the gzip stored-block framer.
// ----------------------------------------------------------------------------
package gzsb_pkg;

  localparam int unsigned MAX_CHUNK_DEF = 65535;
  localparam int unsigned GZ_HDR_LEN    = 10;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam logic [31:0] CRC_POLY      = 32'hEDB88320;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_EOS  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [0:0]  kind;
    logic [7:0]  data_byte;
    logic [0:0]  chunk_start;
    logic [15:0] chunk_len;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [0:0] run_last;
    logic [0:0] stream_done;
  } out_item_t;

  // One classified request, handed from the front to the back.
  typedef struct packed {
    logic        gz_hdr;
    logic        eos;
    logic        start;
    logic [7:0]  data_byte;
    logic [15:0] len;
    logic [31:0] crc;
    logic [31:0] total;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_NEW,
    PH_GZ,
    PH_BLK,
    PH_DATA,
    PH_FIN,
    PH_CRC,
    PH_SIZE
  } phase_t;

  // Reflected CRC-32, one byte; each step is a shift and a masked xor.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return ~c;
  endfunction

  function automatic logic [7:0] gz_hdr_byte(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'h1F;
      4'd1:    v = 8'h8B;
      4'd2:    v = 8'h08;
      4'd9:    v = 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

[src/gzsb_stream_if.sv]
// ----------------------------------------------------------------------------
// gzsb_stream_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface gzsb_stream_if #(parameter type T = logic [7:0]);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[src/gzip_stored_block_framer.sv]
// ----------------------------------------------------------------------------
// gzip_stored_block_framer
// Frames a byte stream as a gzip file of DEFLATE stored blocks with CRC-32
// and ISIZE trailer.
// ----------------------------------------------------------------------------
// Usage:
//   items  : input requests (kind, data_byte, chunk_start, chunk_len) on a
//            valid/ready channel; a request moves when valid and ready are high.
//   stream : output bytes (out_byte, run_last, stream_done), same handshake.
//   The first request of a stream emits the 10-byte gzip header first. A data
//   byte with chunk_start emits 00, LEN, NLEN ahead of itself. End of stream
//   emits 01 00 00 FF FF, the CRC-32 and the byte count, then clears the
//   stream state so the next request opens a new file.
// Path: a request taken is written into the request queue, and its first byte
//   is then loaded from the queue head into the output register of the back end.
// Throughput: one output byte per cycle while stream.ready allows, set by the
//   single output register of the back end. A plain data byte yields 1 output
//   byte, a chunk start 6, end of stream 13, and the first request of a stream
//   10 more. Input is taken every cycle while the request queue has room.
// Reset: clears the CRC, the byte count, the header flag, the queue pointers
//   and count, and the output valid flag. No clearing pass.
// Stall: a valid output register holds while stream.ready is low, the back end
//   stops, and the two-entry queue fills before items.ready drops.
// ----------------------------------------------------------------------------
module gzip_stored_block_framer #(
  parameter int unsigned MAX_CHUNK = gzsb_pkg::MAX_CHUNK_DEF
) (
  input  logic          clk,
  input  logic          rst,
  gzsb_stream_if.sink   items,
  gzsb_stream_if.source stream
);
  import gzsb_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  // Front: take requests, update CRC and size, classify.
  gzsb_front #(
    .MAX_CHUNK (MAX_CHUNK)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decouple the two sides so each may stall alone.
  gzsb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back: advance through the bytes of the head request.
  gzsb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .stream     (stream)
  );

endmodule

[src/gzsb_queue.sv]
// ----------------------------------------------------------------------------
// gzsb_queue
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module gzsb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gzsb_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output gzsb_pkg::cmd_t head_cmd
);
  import gzsb_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/gzsb_front.sv]
// ----------------------------------------------------------------------------
// gzsb_front
// Accept input items, keep the running CRC and size, classify each request.
// ----------------------------------------------------------------------------
module gzsb_front #(
  parameter int unsigned MAX_CHUNK = gzsb_pkg::MAX_CHUNK_DEF
) (
  input  logic           clk,
  input  logic           rst,
  gzsb_stream_if.sink    items,
  input  logic           full,
  output logic           push,
  output gzsb_pkg::cmd_t push_cmd
);
  import gzsb_pkg::*;

  localparam logic [15:0] MAX_LEN = 16'(MAX_CHUNK);

  logic [31:0] crc_reg;
  logic [31:0] byte_total;
  logic        header_sent;
  in_item_t    it;
  logic        is_eos;
  logic [15:0] len_sat;

  assign it          = items.payload;
  assign items.ready = !full;
  assign push        = items.valid && !full;
  assign is_eos      = (it.kind == KIND_EOS);
  assign len_sat     = (it.chunk_len > MAX_LEN) ? MAX_LEN : it.chunk_len;

  always_comb begin
    push_cmd.gz_hdr    = !header_sent;
    push_cmd.eos       = is_eos;
    push_cmd.start     = !is_eos && it.chunk_start[0];
    push_cmd.data_byte = it.data_byte;
    push_cmd.len       = len_sat;
    push_cmd.crc       = crc_reg;
    push_cmd.total     = byte_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg     <= '0;
      byte_total  <= '0;
      header_sent <= 1'b0;
    end else if (push) begin
      if (is_eos) begin
        // drop stream state once the trailer is queued
        crc_reg     <= '0;
        byte_total  <= '0;
        header_sent <= 1'b0;
      end else begin
        crc_reg     <= crc_byte(crc_reg, it.data_byte);
        byte_total  <= byte_total + 32'd1;
        header_sent <= 1'b1;
      end
    end
  end

endmodule

[src/gzsb_back.sv]
// ----------------------------------------------------------------------------
// gzsb_back
// Expand queued requests into output bytes, one per cycle while the output is
// not stalled, into an output register.
// ----------------------------------------------------------------------------
module gzsb_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  gzsb_pkg::cmd_t head_cmd,
  output logic           pop,
  gzsb_stream_if.source  stream
);
  import gzsb_pkg::*;

  phase_t     phase, phase_next;
  logic [3:0] idx, idx_next;
  logic       out_valid;
  out_item_t  out_reg;

  phase_t     cur_ph;
  phase_t     after_ph;
  logic [7:0] cur_byte;
  logic       at_end;
  logic       is_final;
  logic       load;
  logic       fire;

  assign stream.valid   = out_valid;
  assign stream.payload = out_reg;
  assign load           = !out_valid || stream.ready;
  assign fire           = head_valid && load;

  always_comb begin
    // where a fresh request begins, and where it goes after the gzip header
    if (head_cmd.eos) begin
      after_ph = PH_FIN;
    end else if (head_cmd.start) begin
      after_ph = PH_BLK;
    end else begin
      after_ph = PH_DATA;
    end
    if (phase == PH_NEW) begin
      cur_ph = head_cmd.gz_hdr ? PH_GZ : after_ph;
    end else begin
      cur_ph = phase;
    end

    cur_byte = 8'h00;
    at_end   = 1'b0;
    is_final = 1'b0;
    case (cur_ph)
      PH_GZ: begin
        cur_byte = gz_hdr_byte(idx);
        at_end   = (idx == 4'(GZ_HDR_LEN - 1));
      end
      PH_BLK: begin
        case (idx[2:0])
          3'd0:    cur_byte = 8'h00;
          3'd1:    cur_byte = head_cmd.len[7:0];
          3'd2:    cur_byte = head_cmd.len[15:8];
          3'd3:    cur_byte = ~head_cmd.len[7:0];
          default: cur_byte = ~head_cmd.len[15:8];
        endcase
        at_end = (idx == 4'd4);
      end
      PH_DATA: begin
        cur_byte = head_cmd.data_byte;
        at_end   = 1'b1;
        is_final = 1'b1;
      end
      PH_FIN: begin
        case (idx[2:0])
          3'd0:    cur_byte = 8'h01;
          3'd1:    cur_byte = 8'h00;
          3'd2:    cur_byte = 8'h00;
          default: cur_byte = 8'hFF;
        endcase
        at_end = (idx == 4'd4);
      end
      PH_CRC: begin
        cur_byte = head_cmd.crc[{idx[1:0], 3'b000} +: 8];
        at_end   = (idx == 4'd3);
      end
      PH_SIZE: begin
        cur_byte = head_cmd.total[{idx[1:0], 3'b000} +: 8];
        at_end   = (idx == 4'd3);
        is_final = at_end;
      end
      default: begin
        cur_byte = 8'h00;
      end
    endcase

    phase_next = phase;
    idx_next   = idx;
    pop        = 1'b0;
    if (fire) begin
      if (!at_end) begin
        phase_next = cur_ph;
        idx_next   = idx + 4'd1;
      end else begin
        idx_next = 4'd0;
        case (cur_ph)
          PH_GZ:   phase_next = after_ph;
          PH_BLK:  phase_next = PH_DATA;
          PH_FIN:  phase_next = PH_CRC;
          PH_CRC:  phase_next = PH_SIZE;
          default: phase_next = PH_NEW;
        endcase
        pop = is_final;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NEW;
      idx   <= 4'd0;
    end else begin
      phase <= phase_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_reg.out_byte    <= cur_byte;
      out_reg.run_last    <= is_final;
      out_reg.stream_done <= is_final && (cur_ph == PH_SIZE);
    end
  end

endmodule
